// ===== rtl/bpf_pkg.sv =====
// Shared types, codes and sequencing tables for the Bezier path flattener.
`timescale 1ns / 1ps

package bpf_pkg;

    localparam int REQ_W   = 3;
    localparam int KIND_W  = 2;
    localparam int DEPTH_W = 3;
    localparam int PORT_W  = 32;
    localparam int STEP_W  = 3;

    // segment kinds on the input side
    localparam logic [REQ_W-1:0] REQ_MOVE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LINE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUAD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CUBIC = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 3'd4;

    // point kinds on the output side
    localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_MID,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } t_state;

    typedef logic [STEP_W-1:0] t_step;

    // Working row holds one sub-curve with control points at even slots.
    // Each op writes slot d with the midpoint of slots d-1 and d+1.
    function automatic t_step mid_dst(input logic cubic, input t_step step);
        t_step d;
        d = 3'd1;
        if (cubic) begin
            unique case (step)
                3'd0:    d = 3'd1;
                3'd1:    d = 3'd3;
                3'd2:    d = 3'd5;
                3'd3:    d = 3'd2;
                3'd4:    d = 3'd4;
                3'd5:    d = 3'd3;
                default: d = 3'd1;
            endcase
        end else begin
            unique case (step)
                3'd0:    d = 3'd1;
                3'd1:    d = 3'd3;
                3'd2:    d = 3'd2;
                default: d = 3'd1;
            endcase
        end
        return d;
    endfunction

    function automatic t_step mid_last(input logic cubic);
        return cubic ? 3'd5 : 3'd2;
    endfunction

endpackage

// ===== rtl/bezier_path_flattener_unit.sv =====
// Top level of the Bezier path flattener: sequencer, polygon store, output register.
`timescale 1ns / 1ps
// Move, line, close: result registered at accept; block busy until it is taken.
// Curve (deg 2 or 3, depth D): deg+1 seed writes, then per pass per sub-curve
//   (deg+1) store reads + (3*deg-3) midpoint ops + 2*deg writes (+1 on last sub-curve),
//   then a store read, and per emitted point a load and an output beat.
// Midpoint unit and store ports are shared; o_in_stall high from accept to last beat.
// Synchronous active-low reset: idle, current point zero, depth 3; store is not cleared.

module bezier_path_flattener_unit #(
    parameter int MAX_DEPTH   = 4,
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // segment input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bpf_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [bpf_pkg::PORT_W-1:0] i_x0,
    input  logic signed [bpf_pkg::PORT_W-1:0] i_y0,
    input  logic signed [bpf_pkg::PORT_W-1:0] i_x1,
    input  logic signed [bpf_pkg::PORT_W-1:0] i_y1,
    input  logic signed [bpf_pkg::PORT_W-1:0] i_x2,
    input  logic signed [bpf_pkg::PORT_W-1:0] i_y2,
    // point output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bpf_pkg::KIND_W-1:0]        o_point_kind,
    output logic signed [bpf_pkg::PORT_W-1:0] o_out_x,
    output logic signed [bpf_pkg::PORT_W-1:0] o_out_y,
    output logic                              o_last,
    // subdivision depth register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpf_pkg::DEPTH_W-1:0]       i_cfg_data
);

    import bpf_pkg::*;

    localparam int CW          = COORD_WIDTH;
    localparam int PT_W        = 2 * COORD_WIDTH;
    localparam int STORE_DEPTH = 3 * (2 ** MAX_DEPTH) + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PASS_W      = $clog2(MAX_DEPTH + 1);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state             r_state, n_state;
    t_step              r_step, n_step;
    logic               r_cubic;
    logic [DEPTH_W-1:0] r_depth;
    logic [PASS_W-1:0]  r_dlim;      // effective pass count of this curve
    logic [PASS_W-1:0]  r_pass;
    logic               r_bank;      // bank holding the current polygon
    logic [IDX_W-1:0]   r_base;      // first point of sub-curve in source bank
    logic [IDX_W-1:0]   r_span;      // segments in current polygon
    logic [IDX_W-1:0]   r_eidx;      // next point to emit
    logic signed [CW-1:0] r_cur_x, r_cur_y;

    // payload
    logic [PT_W-1:0]    r_pt  [0:2]; // control points of the curve
    logic [PT_W-1:0]    r_lpt [0:6]; // working row of one sub-curve
    logic               r_rvalid;
    logic [1:0]         r_rslot;
    logic [PT_W-1:0]    r_rd_data;
    logic [KIND_W-1:0]  r_out_kind;
    logic signed [CW-1:0] r_out_x, r_out_y;
    logic               r_out_last;

    // polygon store, ping-pong banks
    logic [PT_W-1:0]    r_mem [0:1][0:STORE_DEPTH-1];

    // control strobes
    logic               w_in_accept, w_out_accept;
    logic               rd_en, wr_en;
    logic               rd_bank, wr_bank;
    logic [IDX_W-1:0]   rd_idx, wr_idx;
    logic [PT_W-1:0]    wr_data;
    logic [IDX_W-1:0]   w_deg;
    logic [IDX_W-1:0]   w_dst_base;
    logic               w_last_sub;
    logic               w_wr_end;
    logic               w_seed_end;
    t_step              w_deg_step;
    t_step              w_dst;
    logic [PT_W-1:0]    w_mid;
    logic [PASS_W-1:0]  w_dlim_new;

    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = o_out_valid && !i_out_stall;

    assign w_deg      = r_cubic ? IDX_W'(3) : IDX_W'(2);
    assign w_deg_step = r_cubic ? 3'd3 : 3'd2;
    assign w_last_sub = (r_base + w_deg) == r_span;
    assign w_dst_base = {r_base[IDX_W-2:0], 1'b0};
    assign w_seed_end = (r_step == w_deg_step);
    // last sub-curve of a pass also writes the closing end point
    assign w_wr_end   = w_last_sub ? (r_step == {w_deg_step[1:0], 1'b0})
                                   : (r_step == {w_deg_step[1:0], 1'b0} - 3'd1);
    assign w_dlim_new = (r_depth > DEPTH_W'(MAX_DEPTH)) ? PASS_W'(MAX_DEPTH)
                                                        : PASS_W'(r_depth);

    // ---------------------------------------------------------------
    // shared midpoint unit
    // ---------------------------------------------------------------
    assign w_dst = mid_dst(r_cubic, r_step);

    bpf_mid #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mid (
        .i_a   (r_lpt[w_dst - 3'd1]),
        .i_b   (r_lpt[w_dst + 3'd1]),
        .o_mid (w_mid)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        rd_en   = 1'b0;
        rd_bank = r_bank;
        rd_idx  = r_base + IDX_W'(r_step);
        wr_en   = 1'b0;
        wr_bank = !r_bank;
        wr_idx  = w_dst_base + IDX_W'(r_step);
        wr_data = r_lpt[r_step];
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_step = '0;
                    priority case (i_req_type)
                        REQ_QUAD, REQ_CUBIC:           n_state = ST_SEED;
                        REQ_MOVE, REQ_LINE, REQ_CLOSE: n_state = ST_OUT;
                        default:                       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEED: begin
                // bank 0: current point, then the control points
                wr_en   = 1'b1;
                wr_bank = 1'b0;
                wr_idx  = IDX_W'(r_step);
                wr_data = (r_step == '0) ? {r_cur_x, r_cur_y} : r_pt[r_step[1:0] - 2'd1];
                n_step  = r_step + 3'd1;
                if (w_seed_end) begin
                    n_step  = '0;
                    n_state = (r_dlim == '0) ? ST_EMIT_RD : ST_READ;
                end
            end
            ST_READ: begin
                rd_en  = 1'b1;
                n_step = r_step + 3'd1;
                if (w_seed_end) begin
                    n_step  = '0;
                    n_state = ST_MID;
                end
            end
            ST_MID: begin
                n_step = r_step + 3'd1;
                if (r_step == mid_last(r_cubic)) begin
                    n_step  = '0;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_en  = 1'b1;
                n_step = r_step + 3'd1;
                if (w_wr_end) begin
                    n_step = '0;
                    if (w_last_sub && (r_pass + PASS_W'(1) == r_dlim)) begin
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_idx  = r_eidx;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_accept) begin
                    if (r_out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // fetch the next point while this beat leaves
                        rd_en   = 1'b1;
                        rd_idx  = r_eidx;
                        n_state = ST_EMIT_LD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= DEPTH_RESET;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_cubic  <= 1'b0;
            r_dlim   <= '0;
            r_pass   <= '0;
            r_bank   <= 1'b0;
            r_base   <= '0;
            r_span   <= '0;
            r_eidx   <= '0;
            r_rvalid <= 1'b0;
            r_rslot  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_depth <= i_cfg_data;
            end
            r_rvalid <= (r_state == ST_READ);
            r_rslot  <= r_step[1:0];
            if (r_state == ST_IDLE && w_in_accept) begin
                r_cubic <= (i_req_type == REQ_CUBIC);
                r_dlim  <= w_dlim_new;
                r_pass  <= '0;
                r_bank  <= 1'b0;
                r_base  <= '0;
                r_span  <= (i_req_type == REQ_CUBIC) ? IDX_W'(3) : IDX_W'(2);
                r_eidx  <= IDX_W'(1);
                if (i_req_type == REQ_MOVE || i_req_type == REQ_LINE) begin
                    r_cur_x <= i_x0[CW-1:0];
                    r_cur_y <= i_y0[CW-1:0];
                end
            end
            if (r_state == ST_WRITE && w_wr_end) begin
                if (w_last_sub) begin
                    r_pass <= r_pass + PASS_W'(1);
                    r_bank <= !r_bank;
                    r_base <= '0;
                    r_span <= {r_span[IDX_W-2:0], 1'b0};
                end else begin
                    r_base <= r_base + w_deg;
                end
            end
            if (r_state == ST_EMIT_LD) begin
                r_eidx <= r_eidx + IDX_W'(1);
                if (r_eidx == r_span) begin
                    r_cur_x <= r_rd_data[PT_W-1:CW];
                    r_cur_y <= r_rd_data[CW-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_accept) begin
            r_pt[0]    <= {i_x0[CW-1:0], i_y0[CW-1:0]};
            r_pt[1]    <= {i_x1[CW-1:0], i_y1[CW-1:0]};
            r_pt[2]    <= {i_x2[CW-1:0], i_y2[CW-1:0]};
            r_out_last <= 1'b1;
            if (i_req_type == REQ_CLOSE) begin
                r_out_kind <= KIND_CLOSE;
                r_out_x    <= r_cur_x;
                r_out_y    <= r_cur_y;
            end else begin
                r_out_kind <= (i_req_type == REQ_MOVE) ? KIND_MOVE : KIND_LINE;
                r_out_x    <= i_x0[CW-1:0];
                r_out_y    <= i_y0[CW-1:0];
            end
        end
        if (r_state == ST_EMIT_LD) begin
            r_out_kind <= KIND_LINE;
            r_out_x    <= r_rd_data[PT_W-1:CW];
            r_out_y    <= r_rd_data[CW-1:0];
            r_out_last <= (r_eidx == r_span);
        end
        // store read lands on the even slots of the working row
        if (r_rvalid) begin
            r_lpt[{r_rslot, 1'b0}] <= r_rd_data;
        end
        if (r_state == ST_MID) begin
            r_lpt[w_dst] <= w_mid;
        end
    end

    // polygon store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_bank][wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_bank][rd_idx];
        end
    end

    // ---------------------------------------------------------------
    // ports
    // ---------------------------------------------------------------
    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = (r_state == ST_OUT);
    assign o_point_kind = r_out_kind;
    assign o_out_x      = PORT_W'(r_out_x);
    assign o_out_y      = PORT_W'(r_out_y);
    assign o_last       = r_out_last;
    assign o_cfg_ready  = 1'b1;

`ifndef SYNTH
    // a waiting beat always blocks new segments
    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("output beat pending while input open");

    // after the final beat of a segment the block is open again
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_in_stall)
        else $error("block not idle after last beat");

    // the refined polygon never outgrows the store
    a_span_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_span <= IDX_W'(STORE_DEPTH - 1)))
        else $error("polygon span beyond store depth");

    // pass count stays within the curve's depth
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_pass <= r_dlim))
        else $error("pass counter overrun");

    // emitted points never run past the polygon end
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_LD) |-> (r_eidx <= r_span && r_eidx != '0))
        else $error("emit index out of polygon");
`endif

endmodule

// ===== rtl/bpf_mid.sv =====
// Point midpoint unit: floor((a + b) / 2) on both coordinates.
`timescale 1ns / 1ps

module bpf_mid #(
    parameter int COORD_WIDTH = 32
) (
    input  logic [2*COORD_WIDTH-1:0] i_a,
    input  logic [2*COORD_WIDTH-1:0] i_b,
    output logic [2*COORD_WIDTH-1:0] o_mid
);

    localparam int CW = COORD_WIDTH;

    logic signed [CW:0] w_sum_x;
    logic signed [CW:0] w_sum_y;

    // exact sum one bit wider, arithmetic shift right by one
    assign w_sum_x = (CW+1)'(signed'(i_a[2*CW-1:CW])) + (CW+1)'(signed'(i_b[2*CW-1:CW]));
    assign w_sum_y = (CW+1)'(signed'(i_a[CW-1:0])) + (CW+1)'(signed'(i_b[CW-1:0]));

    assign o_mid = {w_sum_x[CW:1], w_sum_y[CW:1]};

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for bezier_path_flattener_unit: directed table plus random paths.
`timescale 1ns / 1ps

module testbench;
    import bpf_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_DEPTH     = 4;
    localparam int STORE_PTS     = 3 * (1 << MAX_DEPTH) + 1;
    localparam int PHASE_ITEMS   = 29;
    localparam int HOLD_CYCLES   = 300;   // one long receiver hold-off
    localparam int SETTLE_CYCLES = 8;     // lets an ignored segment retire before a depth write
    localparam int TAIL_CYCLES   = 40;
    localparam int IDLE_LIMIT    = 4000;  // covers the longest curve plus the receiver hold-off

    localparam logic signed [PORT_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [PORT_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [PORT_W-1:0] ALL_ONES  = -32'sd1;

    // depth settings walked after the directed part (which runs at the reset depth)
    localparam logic [DEPTH_W-1:0] DEPTH_PLAN [8] = '{3'd0, 3'd4, 3'd7, 3'd1,
                                                     3'd2, 3'd5, 3'd6, 3'd3};

    typedef struct packed {
        logic [REQ_W-1:0]         req;
        logic signed [PORT_W-1:0] x0, y0, x1, y1, x2, y2;
    } t_segment;

    // how a table row is checked: by the path model, one typed point, or no point at all
    typedef enum logic [1:0] {CHK_PRED, CHK_POINT, CHK_NONE} t_row_check;

    typedef struct packed {
        t_segment                 seg;
        t_row_check               chk;
        logic [KIND_W-1:0]        kind;
        logic signed [PORT_W-1:0] ex, ey;
    } t_plan_row;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [PORT_W-1:0] x, y;
        logic                     last;
    } t_path_point;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [REQ_W-1:0]         i_req_type;
    logic signed [PORT_W-1:0] i_x0, i_y0, i_x1, i_y1, i_x2, i_y2;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [KIND_W-1:0]        o_point_kind;
    logic signed [PORT_W-1:0] o_out_x, o_out_y;
    logic                     o_last;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [DEPTH_W-1:0]       i_cfg_data;

    // path model state
    logic signed [PORT_W-1:0] pen_x, pen_y;
    logic [DEPTH_W-1:0]       depth_reg;
    t_path_point              pending_pts[$];
    t_plan_row                directed_rows[$];

    int unsigned mismatches    = 0;
    int unsigned beats_taken   = 0;
    int unsigned idle_cycles   = 0;
    int unsigned segments_sent = 0;
    int unsigned curves_sent   = 0;
    int unsigned curve_points  = 0;
    bit          hold_done     = 1'b0;

    bezier_path_flattener_unit #(
        .MAX_DEPTH   (MAX_DEPTH),
        .COORD_WIDTH (PORT_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_x0         (i_x0),
        .i_y0         (i_y0),
        .i_x1         (i_x1),
        .i_y1         (i_y1),
        .i_x2         (i_x2),
        .i_y2         (i_y2),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_point_kind (o_point_kind),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // floor((a + b) / 2) with the sum kept at 33 bits
    function automatic logic signed [PORT_W-1:0] halfway(input logic signed [PORT_W-1:0] a,
                                                         input logic signed [PORT_W-1:0] b);
        logic signed [PORT_W:0] s;
        s = {a[PORT_W-1], a} + {b[PORT_W-1], b};
        return s[PORT_W:1];
    endfunction

    // appends one point to the expected stream
    function automatic void expect_point(input t_path_point p);
        pending_pts = {pending_pts, p};
    endfunction

    // Runs one segment through the path model; queues its points when 'record' is set.
    task automatic flatten_segment(input t_segment seg, input bit record);
        logic signed [PORT_W-1:0] px [STORE_PTS];
        logic signed [PORT_W-1:0] py [STORE_PTS];
        logic signed [PORT_W-1:0] qx [STORE_PTS];
        logic signed [PORT_W-1:0] qy [STORE_PTS];
        logic signed [PORT_W-1:0] ax, ay, cx, cy, mx, my, fx, fy, bx, by, ex, ey;
        int unsigned deg, depth, n, o, b, total;
        t_path_point pt;
        case (seg.req)
            REQ_MOVE, REQ_LINE: begin
                pen_x = seg.x0;
                pen_y = seg.y0;
                pt = '{(seg.req == REQ_MOVE) ? KIND_MOVE : KIND_LINE, seg.x0, seg.y0, 1'b1};
                if (record) expect_point(pt);
            end
            REQ_CLOSE: begin
                pt = '{KIND_CLOSE, pen_x, pen_y, 1'b1};
                if (record) expect_point(pt);
            end
            REQ_QUAD, REQ_CUBIC: begin
                deg   = (seg.req == REQ_CUBIC) ? 3 : 2;
                depth = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
                px[0] = pen_x;  py[0] = pen_y;
                px[1] = seg.x0; py[1] = seg.y0;
                px[2] = seg.x1; py[2] = seg.y1;
                px[3] = seg.x2; py[3] = seg.y2;
                n = 1;
                repeat (depth) begin
                    o = 0;
                    for (int k = 0; k < n; k++) begin
                        b = k * deg;
                        if (deg == 2) begin
                            ax = halfway(px[b], px[b+1]);   ay = halfway(py[b], py[b+1]);
                            cx = halfway(px[b+1], px[b+2]); cy = halfway(py[b+1], py[b+2]);
                            qx[o]   = px[b];            qy[o]   = py[b];
                            qx[o+1] = ax;               qy[o+1] = ay;
                            qx[o+2] = halfway(ax, cx);  qy[o+2] = halfway(ay, cy);
                            qx[o+3] = cx;               qy[o+3] = cy;
                            o += 4;
                        end else begin
                            ax = halfway(px[b], px[b+1]);   ay = halfway(py[b], py[b+1]);
                            mx = halfway(px[b+1], px[b+2]); my = halfway(py[b+1], py[b+2]);
                            fx = halfway(px[b+2], px[b+3]); fy = halfway(py[b+2], py[b+3]);
                            bx = halfway(ax, mx);           by = halfway(ay, my);
                            ex = halfway(mx, fx);           ey = halfway(my, fy);
                            qx[o]   = px[b];            qy[o]   = py[b];
                            qx[o+1] = ax;               qy[o+1] = ay;
                            qx[o+2] = bx;               qy[o+2] = by;
                            qx[o+3] = halfway(bx, ex);  qy[o+3] = halfway(by, ey);
                            qx[o+4] = ex;               qy[o+4] = ey;
                            qx[o+5] = fx;               qy[o+5] = fy;
                            o += 6;
                        end
                    end
                    qx[o] = px[n * deg];
                    qy[o] = py[n * deg];
                    for (int k = 0; k <= o; k++) begin
                        px[k] = qx[k];
                        py[k] = qy[k];
                    end
                    n *= 2;
                end
                total = n * deg;
                for (int i = 1; i <= total; i++) begin
                    pt = '{KIND_LINE, px[i], py[i], (i == total)};
                    if (record) expect_point(pt);
                end
                pen_x = px[total];
                pen_y = py[total];
                curves_sent++;
                curve_points += total;
            end
            default: ;  // unknown kinds leave everything alone
        endcase
    endtask

    function automatic void add_row(input logic [REQ_W-1:0] req,
                                    input logic signed [PORT_W-1:0] x0, y0, x1, y1, x2, y2,
                                    input t_row_check chk, input logic [KIND_W-1:0] kind,
                                    input logic signed [PORT_W-1:0] ex, ey);
        t_plan_row r;
        r = '{'{req, x0, y0, x1, y1, x2, y2}, chk, kind, ex, ey};
        directed_rows = {directed_rows, r};
    endfunction

    // mostly full-range values, some small ones and the rails
    function automatic logic signed [PORT_W-1:0] pick_coord();
        int unsigned r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            v = $urandom;
        end else if (r < 8) begin
            v = int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        end else if (r == 8) begin
            case ($urandom_range(0, 3))
                0:       v = COORD_MAX;
                1:       v = COORD_MIN;
                2:       v = ALL_ONES;
                default: v = 0;
            endcase
        end else begin
            v = int'($urandom_range(0, 6)) - 3;  // odd sums near zero exercise the floor
        end
        return v;
    endfunction

    function automatic t_plan_row draw_segment();
        t_plan_row r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)      r.seg.req = REQ_MOVE;
        else if (pick < 25) r.seg.req = REQ_LINE;
        else if (pick < 55) r.seg.req = REQ_QUAD;
        else if (pick < 85) r.seg.req = REQ_CUBIC;
        else if (pick < 95) r.seg.req = REQ_CLOSE;
        else                r.seg.req = REQ_W'($urandom_range(5, 7));
        r.seg.x0 = pick_coord(); r.seg.y0 = pick_coord();
        r.seg.x1 = pick_coord(); r.seg.y1 = pick_coord();
        r.seg.x2 = pick_coord(); r.seg.y2 = pick_coord();
        r.chk  = CHK_PRED;
        r.kind = KIND_MOVE;
        r.ex   = '0;
        r.ey   = '0;
        return r;
    endfunction

    // Offers one segment beat after a random gap; called and returns at a falling edge.
    task automatic offer_row(input t_plan_row row);
        int unsigned gap, r;
        t_path_point pt;
        r = $urandom_range(0, 99);
        if (r < 70)      gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else             gap = $urandom_range(10, 40);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type <= row.seg.req;
        i_x0       <= row.seg.x0;
        i_y0       <= row.seg.y0;
        i_x1       <= row.seg.x1;
        i_y1       <= row.seg.y1;
        i_x2       <= row.seg.x2;
        i_y2       <= row.seg.y2;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        segments_sent++;
        flatten_segment(row.seg, row.chk == CHK_PRED);
        if (row.chk == CHK_POINT) begin
            pt = '{row.kind, row.ex, row.ey, 1'b1};
            expect_point(pt);
        end
        @(negedge i_clk);
    endtask

    // Receiver: random stall stretches, free-running stretches, one long hold-off.
    initial begin
        int unsigned stall_left, free_left, r;
        stall_left  = 0;
        free_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && beats_taken >= 60) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                free_left  = 0;
            end
            if (stall_left == 0 && free_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 45)      free_left  = $urandom_range(1, 6);
                else if (r < 55) free_left  = $urandom_range(20, 80);
                else if (r < 92) stall_left = $urandom_range(1, 3);
                else             stall_left = $urandom_range(10, 40);
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    // Point checker: every accepted beat against the oldest pending point.
    always @(posedge i_clk) begin
        t_path_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_taken++;
            if (pending_pts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected point kind %0d x %h y %h last %0d",
                         $time, o_point_kind, o_out_x, o_out_y, o_last);
            end else begin
                want = pending_pts.pop_front();
                if (o_point_kind !== want.kind || o_out_x !== want.x ||
                    o_out_y !== want.y || o_last !== want.last) begin
                    mismatches++;
                    $display("%0t: expected kind %0d x %h y %h last %0d, got kind %0d x %h y %h last %0d",
                             $time, want.kind, want.x, want.y, want.last,
                             o_point_kind, o_out_x, o_out_y, o_last);
                end
            end
        end
    end

    // Watchdog: counts cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d points outstanding",
                     $time, IDLE_LIMIT, pending_pts.size());
            $display("bezier_path_flattener_unit: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_MOVE;
        i_x0        = '0;
        i_y0        = '0;
        i_x1        = '0;
        i_y1        = '0;
        i_x2        = '0;
        i_y2        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = DEPTH_RESET;
        pen_x       = '0;
        pen_y       = '0;
        depth_reg   = DEPTH_RESET;

        // Directed part, at the reset depth. Rows checked by a single point carry their answer.
        // close right after reset: pen sits at the origin
        add_row(REQ_CLOSE, 0, 0, 0, 0, 0, 0, CHK_POINT, KIND_CLOSE, 0, 0);
        add_row(REQ_MOVE, COORD_MAX, COORD_MIN, 0, 0, 0, 0, CHK_POINT, KIND_MOVE,
                COORD_MAX, COORD_MIN);
        add_row(REQ_CLOSE, 5, 6, 7, 8, 9, 10, CHK_POINT, KIND_CLOSE, COORD_MAX, COORD_MIN);
        // unused point fields of a line are junk
        add_row(REQ_LINE, COORD_MIN, COORD_MAX, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                CHK_POINT, KIND_LINE, COORD_MIN, COORD_MAX);
        // unknown kinds: nothing comes out and the pen stays put
        add_row(3'd5, 1, 2, 3, 4, 5, 6, CHK_NONE, KIND_MOVE, 0, 0);
        add_row(3'd6, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                CHK_NONE, KIND_MOVE, 0, 0);
        add_row(3'd7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                CHK_NONE, KIND_MOVE, 0, 0);
        add_row(REQ_CLOSE, 0, 0, 0, 0, 0, 0, CHK_POINT, KIND_CLOSE, COORD_MIN, COORD_MAX);
        // curves between the rails
        add_row(REQ_QUAD, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, ALL_ONES, ALL_ONES,
                CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_CUBIC, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_MOVE, ALL_ONES, ALL_ONES, 0, 0, 0, 0, CHK_POINT, KIND_MOVE,
                ALL_ONES, ALL_ONES);
        // tiny odd coordinates: midpoints round toward minus infinity
        add_row(REQ_QUAD, 0, 0, ALL_ONES, 0, 0, 0, CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_CUBIC, 1, ALL_ONES, -32'sd2, 3, -32'sd3, -32'sd5, CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_LINE, 0, 0, 0, 0, 0, 0, CHK_POINT, KIND_LINE, 0, 0);
        add_row(REQ_CUBIC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_QUAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0,
                CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_CLOSE, 0, 0, 0, 0, 0, 0, CHK_PRED, KIND_LINE, 0, 0);
        add_row(REQ_MOVE, 32'sh1234_5678, 32'sh9abc_def0, 0, 0, 0, 0, CHK_POINT, KIND_MOVE,
                32'sh1234_5678, 32'sh9abc_def0);
        add_row(REQ_QUAD, 32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000, 32'sh0000_0001,
                0, 0, CHK_PRED, KIND_LINE, 0, 0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) offer_row(directed_rows[i]);
        i_in_valid <= 1'b0;

        // Random phases, one depth setting each; the depth only changes while idle.
        for (int p = 0; p < 8; p++) begin
            while (pending_pts.size() != 0) @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            i_cfg_data  <= DEPTH_PLAN[p];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            depth_reg = DEPTH_PLAN[p];
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) offer_row(draw_segment());
            i_in_valid <= 1'b0;
        end

        while (pending_pts.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d segments (%0d curves) over depths 3,0,4,7,1,2,5,6,3; %0d points taken",
                 segments_sent, curves_sent, beats_taken);
        $display("Curves produced %0d line points; receiver held off once for %0d cycles",
                 curve_points, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("bezier_path_flattener_unit: match");
        end else begin
            $display("bezier_path_flattener_unit: mismatch");
        end
        $finish;
    end

endmodule
